FILE: design/smsd_pkg.sv
// Shared types, widths and state codes for the sample mean / std deviation block.
`default_nettype none

package smsd_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W      = 24;
    localparam int COUNT_FIELD_W = 13;

    // Sample store
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Datapath widths
    localparam int SUM_W  = SAMPLE_W + ADDR_W + 1;   // running sum, signed
    localparam int DIFF_W = SAMPLE_W + 1;            // sample - mean
    localparam int MAG_W  = SAMPLE_W;                // |sample - mean|
    localparam int SQ_W   = 2 * MAG_W;               // squared deviation
    localparam int SSQ_W  = SQ_W + ADDR_W + 1;       // sum of squares
    localparam int DIVD_W = (SSQ_W > SUM_W) ? SSQ_W : SUM_W;
    localparam int DCNT_W = $clog2(DIVD_W + 1);
    localparam int RT_W   = SAMPLE_W;                // square root width
    localparam int VAR_W  = 2 * RT_W;                // radicand width
    localparam int SCNT_W = $clog2(RT_W + 1);

    // Job queue between intake and compute
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } smsd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [SAMPLE_W-1:0]        std_dev;
        logic [COUNT_FIELD_W-1:0]   sample_count;
        logic                       dropped;
    } smsd_out_t;

    // One finished set, handed from intake to compute
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic                    dropped;
    } smsd_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MDIV,
        ST_DEV,
        ST_VDIV,
        ST_SQRT,
        ST_EMIT
    } smsd_state_t;

endpackage

`default_nettype wire

FILE: design/sample_mean_stddev.sv
// Top level of the sample mean and population standard deviation block.
//
// Samples (signed Q16.8) arrive as beats on the smp channel, one per clock,
// and are written into a 4096-entry store while a running sum and count
// are kept. A beat marked last closes the set: it is stored like any other
// and then intake stalls while the compute engine works. The engine forms
// the mean as sum / count (truncated toward zero) on a shared bit-serial
// divider, walks the stored samples once through a three-stage
// subtract / square / accumulate pipeline, divides the sum of squares by
// the count on the same divider, and takes a floored square root at two
// radicand bits per clock. One result beat (mean, std deviation, count,
// drop flag) goes out on the res channel through an output register, so a
// stalled result does not hold up the next set once the register is
// loaded. Samples beyond the store depth are not stored or summed and set
// the dropped flag. Cost: one clock per sample; after a last beat, intake
// stays stalled through the two divider runs, the store read pass and the
// square root. A result still held in the output register adds its stall
// time.
`default_nettype none

module sample_mean_stddev
    import smsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      smp_valid,
    output logic           smp_stall,
    input  wire smsd_in_t  smp,
    output logic           res_valid,
    input  wire logic      res_stall,
    output smsd_out_t      res
);

    // front -> queue
    logic                  q_push;
    smsd_job_t             q_push_job;
    logic                  q_full;
    // queue -> back
    logic                  q_pop;
    smsd_job_t             q_head;
    logic                  q_empty;
    // between back and front
    logic                  set_done;
    logic [ADDR_W-1:0]     st_rd_addr;
    logic [SAMPLE_W-1:0]   st_rd_data;

    smsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp),
        .job_push  (q_push),
        .job       (q_push_job),
        .job_full  (q_full),
        .job_done  (set_done),
        .rd_addr   (st_rd_addr),
        .rd_data   (st_rd_data)
    );

    // decouples intake from the compute engine
    smsd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    smsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (q_empty),
        .job_head  (q_head),
        .job_pop   (q_pop),
        .job_done  (set_done),
        .rd_addr   (st_rd_addr),
        .rd_data   (st_rd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

FILE: design/smsd_fifo.sv
// Small job queue between the intake and the compute engine.
`default_nettype none

module smsd_fifo
    import smsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire smsd_job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output smsd_job_t      head,
    output logic           empty
);

    smsd_job_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (fill_reg == QCNT_W'(QDEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/smsd_front.sv
// Intake: accepts sample beats, fills the sample store, keeps sum and count.
`default_nettype none

module smsd_front
    import smsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         smp_valid,
    output logic              smp_stall,
    input  wire smsd_in_t     smp,
    // job handoff
    output logic              job_push,
    output smsd_job_t         job,
    input  wire logic         job_full,
    input  wire logic         job_done,
    // store read port for the deviation pass
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0]      rd_data
);

    logic [SAMPLE_W-1:0]     store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0]     rd_data_reg;

    logic [CNT_W-1:0]        count_reg,  count_next;
    logic signed [SUM_W-1:0] sum_reg,    sum_next;
    logic                    ovf_reg,    ovf_next;
    logic                    busy_reg,   busy_next;

    logic                    accept;
    logic                    room;
    logic [CNT_W-1:0]        count_upd;
    logic signed [SUM_W-1:0] sum_upd;
    logic                    ovf_upd;

    // store is held for the compute pass from the last beat until done
    assign smp_stall = busy_reg || job_full;
    assign accept    = smp_valid && !smp_stall;
    assign room      = (count_reg < CNT_W'(STORE_DEPTH));

    always_comb
    begin
        count_upd = room ? count_reg + 1'b1 : count_reg;
        sum_upd   = room ? sum_reg + SUM_W'(smp.sample) : sum_reg;
        ovf_upd   = room ? ovf_reg : 1'b1;

        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;

        if (job_done)
        begin
            busy_next = 1'b0;
        end

        if (accept)
        begin
            if (smp.last)
            begin
                count_next = '0;
                sum_next   = '0;
                ovf_next   = 1'b0;
                busy_next  = 1'b1;
            end
            else
            begin
                count_next = count_upd;
                sum_next   = sum_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    assign job_push    = accept && smp.last;
    assign job.sum     = sum_upd;
    assign job.count   = count_upd;
    assign job.dropped = ovf_upd;

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= smp.sample;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("sample count beyond store depth");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |=> busy_reg && count_reg == '0)
        else $error("last beat did not lock intake and clear the set");

endmodule

`default_nettype wire

FILE: design/smsd_div.sv
// Shared restoring divider: unsigned dividend by count, one quotient bit per cycle.
`default_nettype none

module smsd_div
    import smsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient
);

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [DIVD_W-1:0]   quo_reg;
    logic [CNT_W-1:0]    dvs_reg;

    logic [CNT_W:0]      rem_sh;
    logic                ge;

    assign rem_sh   = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : CNT_W'(rem_sh);
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/smsd_back.sv
// Compute engine: mean, deviation pass, variance, square root, result register.
`default_nettype none

module smsd_back
    import smsd_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    // job queue
    input  wire logic            job_empty,
    input  wire smsd_job_t       job_head,
    output logic                 job_pop,
    output logic                 job_done,
    // store read port
    output logic [ADDR_W-1:0]    rd_addr,
    input  wire logic [SAMPLE_W-1:0] rd_data,
    // result channel
    output logic                 res_valid,
    input  wire logic            res_stall,
    output smsd_out_t            res
);

    smsd_state_t               state_reg, state_next;
    smsd_job_t                 job_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;

    // deviation pass
    logic [CNT_W-1:0]          idx_reg;
    logic                      v1_reg, v2_reg, v3_reg;
    logic [MAG_W-1:0]          ad_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [SSQ_W-1:0]          ssq_reg;

    // square root
    logic [VAR_W-1:0]          rad_reg;
    logic [RT_W+1:0]           rem_reg;
    logic [RT_W-1:0]           root_reg;
    logic [SCNT_W-1:0]         scnt_reg;

    // result register
    logic                      res_valid_reg;
    smsd_out_t                 res_reg;

    // divider
    logic                      div_start;
    logic [DIVD_W-1:0]         div_dividend;
    logic [CNT_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DIVD_W-1:0]         div_quo;

    logic [SUM_W-1:0]          sum_mag;
    logic                      issue;
    logic                      pass_end;
    logic                      out_free;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [RT_W+1:0]           rem_sh;
    logic [RT_W+1:0]           trial;
    logic                      rt_ge;
    logic [SAMPLE_W-1:0]       q_mean;

    smsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sum_mag  = job_head.sum[SUM_W-1] ? SUM_W'(-job_head.sum) : SUM_W'(job_head.sum);
    assign out_free = !res_valid_reg || !res_stall;
    assign issue    = (state_reg == ST_DEV) && (idx_reg < job_reg.count);
    assign pass_end = (state_reg == ST_DEV) && (idx_reg == job_reg.count)
                      && !v1_reg && !v2_reg && !v3_reg;
    assign rd_addr  = idx_reg[ADDR_W-1:0];

    assign diff     = DIFF_W'($signed(rd_data)) - DIFF_W'(mean_reg);
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    assign rem_sh   = {rem_reg[RT_W-1:0], rad_reg[VAR_W-1:VAR_W-2]};
    assign trial    = {root_reg, 2'b01};
    assign rt_ge    = (rem_sh >= trial);

    // quotient magnitude stays within the sample range
    assign q_mean   = job_reg.sum[SUM_W-1] ? SAMPLE_W'(-div_quo[SAMPLE_W-1:0])
                                           : div_quo[SAMPLE_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        job_pop      = 1'b0;
        job_done     = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIVD_W'(sum_mag);
        div_divisor  = job_head.count;

        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV:
            begin
                if (pass_end)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIVD_W'(ssq_reg);
                    div_divisor  = job_reg.count;
                    state_next   = ST_VDIV;
                end
            end
            ST_VDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (scnt_reg == SCNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    job_done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job_head;
        end
        if (state_reg == ST_MDIV && div_done)
        begin
            mean_reg <= q_mean;
            ssq_reg  <= '0;
        end
        if (v1_reg)
        begin
            ad_reg <= diff_mag[MAG_W-1:0];
        end
        if (v2_reg)
        begin
            sq_reg <= ad_reg * ad_reg;
        end
        if (v3_reg)
        begin
            ssq_reg <= ssq_reg + SSQ_W'(sq_reg);
        end
        if (state_reg == ST_VDIV && div_done)
        begin
            rad_reg  <= div_quo[VAR_W-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_SQRT)
        begin
            rad_reg  <= {rad_reg[VAR_W-3:0], 2'b00};
            rem_reg  <= rt_ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RT_W-2:0], rt_ge};
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            res_reg.mean_value   <= mean_reg;
            res_reg.std_dev      <= root_reg;
            res_reg.sample_count <= COUNT_FIELD_W'(job_reg.count);
            res_reg.dropped      <= job_reg.dropped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            scnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (state_reg == ST_MDIV)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == ST_VDIV)
            begin
                scnt_reg <= SCNT_W'(RT_W);
            end
            else if (state_reg == ST_SQRT)
            begin
                scnt_reg <= scnt_reg - 1'b1;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> idx_reg < job_reg.count)
        else $error("store read past the current set");

    a_acc_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg || v3_reg) |-> state_reg == ST_DEV)
        else $error("deviation pipeline busy outside the pass");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> state_reg == ST_IDLE && res_valid_reg)
        else $error("done without a loaded result");

endmodule

`default_nettype wire
